// File: design/ray_cylinder_intersection_macros.svh
// assertion macros for the ray cylinder intersection checker
`ifndef RAY_CYLINDER_INTERSECTION_MACROS_SVH
`define RAY_CYLINDER_INTERSECTION_MACROS_SVH

// property that must hold at every edge outside reset
`define RCI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every edge outside reset
`define RCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/rci_pkg.sv
// types, constants and shared arithmetic for the ray cylinder intersection
package rci_pkg;

  localparam int SQRT_BITS = 48;
  localparam int DISC_W    = 96;
  localparam int QUO_BITS  = 31;
  localparam int NUM_W     = 80;
  localparam int DEN_W     = 95;

  localparam logic [63:0] ONE_SQ_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [31:0] DIST_MAX   = 32'h7fff_ffff;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic               inside_res;
    logic [1:0]         hit_count;
    logic signed [31:0] first_distance;
    logic signed [31:0] first_normal_x;
    logic signed [31:0] first_normal_z;
    logic signed [31:0] second_distance;
    logic signed [31:0] second_normal_x;
    logic signed [31:0] second_normal_z;
  } ray_out_t;

  // per-ray values that ride along the pipeline
  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dz;
    logic [63:0]        a;
    logic signed [65:0] nb;
    logic               in_cyl;
    logic               hasroots;
    logic               tangent;
  } ctx_t;

  function automatic logic signed [63:0] smul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    return x * y;
  endfunction

endpackage

// File: design/rci_coef.sv
// quadratic coefficients and discriminant, six register stages
module rci_coef (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  rci_pkg::ray_in_t              in_ray,
  output logic                          out_valid,
  output rci_pkg::ctx_t                 out_ctx,
  output logic [rci_pkg::DISC_W-1:0]    out_disc
);
  import rci_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  ray_in_t            ray1_r, ray2_r, ray3_r, ray4_r, ray5_r;
  logic signed [63:0] pxx_r, pzz_r, dxx_r, dzz_r, pxdx_r, pzdz_r, pxdz_r, pzdx_r;
  logic [63:0]        a2_r, a3_r, a4_r, a5_r;
  logic               inside2_r, inside3_r, inside4_r, inside5_r;
  logic signed [65:0] b2_r, cr2_r, nb3_r, nb4_r, nb5_r;
  logic signed [65:0] crabs_nxt;
  logic [63:0]        oo_nxt;
  logic [63:0]        crm3_r;
  logic               big4_r, big5_r;
  logic [47:0]        hh4_r, hl4_r, ll4_r;
  logic [DISC_W-1:0]  sq5_r;
  logic [DISC_W-1:0]  lhs_nxt, disc_nxt;
  logic               neg_nxt;
  ctx_t               ctx6_r, ctx_nxt;
  logic [DISC_W-1:0]  disc6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  assign oo_nxt    = 64'(pxx_r) + 64'(pzz_r);
  assign crabs_nxt = cr2_r[65] ? -cr2_r : cr2_r;

  // crm squared as three 24-bit partial products
  assign lhs_nxt  = {a5_r, 32'h0};
  assign neg_nxt  = big5_r || (sq5_r > lhs_nxt);
  assign disc_nxt = lhs_nxt - sq5_r;

  always_comb begin
    ctx_nxt          = '0;
    ctx_nxt.ox       = ray5_r.origin_x;
    ctx_nxt.oz       = ray5_r.origin_z;
    ctx_nxt.dx       = ray5_r.dir_x;
    ctx_nxt.dz       = ray5_r.dir_z;
    ctx_nxt.a        = a5_r;
    ctx_nxt.nb       = nb5_r;
    ctx_nxt.in_cyl   = inside5_r;
    ctx_nxt.hasroots = (a5_r != 64'h0) && !neg_nxt;
    ctx_nxt.tangent  = (disc_nxt == '0);
  end

  always_ff @(posedge clk) begin
    ray1_r    <= in_ray;
    pxx_r     <= smul(in_ray.origin_x, in_ray.origin_x);
    pzz_r     <= smul(in_ray.origin_z, in_ray.origin_z);
    dxx_r     <= smul(in_ray.dir_x, in_ray.dir_x);
    dzz_r     <= smul(in_ray.dir_z, in_ray.dir_z);
    pxdx_r    <= smul(in_ray.origin_x, in_ray.dir_x);
    pzdz_r    <= smul(in_ray.origin_z, in_ray.dir_z);
    pxdz_r    <= smul(in_ray.origin_x, in_ray.dir_z);
    pzdx_r    <= smul(in_ray.origin_z, in_ray.dir_x);

    ray2_r    <= ray1_r;
    a2_r      <= 64'(dxx_r) + 64'(dzz_r);
    inside2_r <= (oo_nxt <= ONE_SQ_Q32);
    b2_r      <= 66'(pxdx_r) + 66'(pzdz_r);
    cr2_r     <= 66'(pxdz_r) - 66'(pzdx_r);

    ray3_r    <= ray2_r;
    a3_r      <= a2_r;
    inside3_r <= inside2_r;
    nb3_r     <= -b2_r;
    crm3_r    <= crabs_nxt[63:0];

    ray4_r    <= ray3_r;
    a4_r      <= a3_r;
    inside4_r <= inside3_r;
    nb4_r     <= nb3_r;
    big4_r    <= |crm3_r[63:48];
    hh4_r     <= crm3_r[47:24] * crm3_r[47:24];
    hl4_r     <= crm3_r[47:24] * crm3_r[23:0];
    ll4_r     <= crm3_r[23:0] * crm3_r[23:0];

    ray5_r    <= ray4_r;
    a5_r      <= a4_r;
    inside5_r <= inside4_r;
    nb5_r     <= nb4_r;
    big5_r    <= big4_r;
    sq5_r     <= {hh4_r, 48'h0} + (DISC_W'(hl4_r) << 25) + DISC_W'(ll4_r);

    ctx6_r    <= ctx_nxt;
    disc6_r   <= disc_nxt;
  end

  assign out_valid = v6_r;
  assign out_ctx   = ctx6_r;
  assign out_disc  = disc6_r;

endmodule

// File: design/rci_sqrt.sv
// floor square root of the discriminant, one result bit per stage
module rci_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  rci_pkg::ctx_t                   in_ctx,
  input  logic [rci_pkg::DISC_W-1:0]      in_disc,
  output logic                            out_valid,
  output rci_pkg::ctx_t                   out_ctx,
  output logic [rci_pkg::SQRT_BITS-1:0]   out_root
);
  import rci_pkg::*;

  logic [SQRT_BITS-1:0] v_r;
  ctx_t                 ctx_r  [SQRT_BITS];
  logic [DISC_W-1:0]    rem_r  [SQRT_BITS];
  logic [SQRT_BITS-1:0] root_r [SQRT_BITS];

  for (genvar i = 0; i < SQRT_BITS; i++) begin : g_stage
    localparam int K = SQRT_BITS - 1 - i;
    logic                 v_in;
    ctx_t                 ctx_in;
    logic [DISC_W-1:0]    rem_in;
    logic [SQRT_BITS-1:0] root_in;
    logic [DISC_W-1:0]    trial;
    logic                 ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign ctx_in  = in_ctx;
      assign rem_in  = in_disc;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign ctx_in  = ctx_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    // (r + 2^k)^2 - r^2
    assign trial = (DISC_W'(root_in) << (K + 1)) + (DISC_W'(1) << (2 * K));
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      ctx_r[i]  <= ctx_in;
      rem_r[i]  <= ge ? rem_in - trial : rem_in;
      root_r[i] <= ge ? (root_in | (SQRT_BITS'(1) << K)) : root_in;
    end
  end

  assign out_valid = v_r[SQRT_BITS-1];
  assign out_ctx   = ctx_r[SQRT_BITS-1];
  assign out_root  = root_r[SQRT_BITS-1];

endmodule

// File: design/rci_div.sv
// root selection and restoring division of both roots by a
module rci_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  rci_pkg::ctx_t                   in_ctx,
  input  logic [rci_pkg::SQRT_BITS-1:0]   in_root,
  output logic                            out_valid,
  output rci_pkg::ctx_t                   out_ctx,
  output logic [1:0]                      out_count,
  output logic [31:0]                     out_dist1,
  output logic [31:0]                     out_dist2
);
  import rci_pkg::*;

  logic               va_r, vb_r;
  ctx_t               ctxa_r, ctxb_r;
  logic signed [65:0] n1a_r, n2a_r;
  logic               k1a_r, k2a_r;
  logic signed [65:0] sroot_nxt;
  logic signed [65:0] n1_nxt, n2_nxt;
  logic [63:0]        nf_nxt, ns_nxt;
  logic [78:0]        alim_nxt;
  logic [1:0]         countb_r;
  logic [NUM_W-1:0]   num1b_r, num2b_r;
  logic               sat1b_r, sat2b_r;

  logic [QUO_BITS-1:0] v_r;
  ctx_t                ctx_r   [QUO_BITS];
  logic [1:0]          count_r [QUO_BITS];
  logic [NUM_W-1:0]    num1_r  [QUO_BITS];
  logic [NUM_W-1:0]    num2_r  [QUO_BITS];
  logic [QUO_BITS-1:0] q1_r    [QUO_BITS];
  logic [QUO_BITS-1:0] q2_r    [QUO_BITS];
  logic                sat1_r  [QUO_BITS];
  logic                sat2_r  [QUO_BITS];

  assign sroot_nxt = $signed({{(66 - SQRT_BITS){1'b0}}, in_root});
  assign n1_nxt    = in_ctx.nb - sroot_nxt;
  assign n2_nxt    = in_ctx.nb + sroot_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  // n1 <= n2, so a kept n1 always comes first
  assign nf_nxt   = k1a_r ? n1a_r[63:0] : n2a_r[63:0];
  assign ns_nxt   = n2a_r[63:0];
  assign alim_nxt = {ctxa_r.a, 15'h0};

  always_ff @(posedge clk) begin
    ctxa_r   <= in_ctx;
    n1a_r    <= n1_nxt;
    n2a_r    <= n2_nxt;
    // a root is kept only when it is non-negative
    k1a_r    <= in_ctx.hasroots && !n1_nxt[65];
    k2a_r    <= in_ctx.hasroots && !in_ctx.tangent && !n2_nxt[65];

    ctxb_r   <= ctxa_r;
    countb_r <= (k1a_r && k2a_r) ? 2'd2 : ((k1a_r || k2a_r) ? 2'd1 : 2'd0);
    num1b_r  <= {nf_nxt, 16'h0};
    num2b_r  <= {ns_nxt, 16'h0};
    sat1b_r  <= ({15'h0, nf_nxt} >= alim_nxt);
    sat2b_r  <= ({15'h0, ns_nxt} >= alim_nxt);
  end

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
    localparam int K = QUO_BITS - 1 - i;
    logic                v_in;
    ctx_t                ctx_in;
    logic [1:0]          count_in;
    logic [NUM_W-1:0]    num1_in, num2_in;
    logic [QUO_BITS-1:0] q1_in, q2_in;
    logic                sat1_in, sat2_in;
    logic [DEN_W-1:0]    sa;
    logic                ge1, ge2;

    if (i == 0) begin : g_first
      assign v_in     = vb_r;
      assign ctx_in   = ctxb_r;
      assign count_in = countb_r;
      assign num1_in  = num1b_r;
      assign num2_in  = num2b_r;
      assign q1_in    = '0;
      assign q2_in    = '0;
      assign sat1_in  = sat1b_r;
      assign sat2_in  = sat2b_r;
    end else begin : g_next
      assign v_in     = v_r[i-1];
      assign ctx_in   = ctx_r[i-1];
      assign count_in = count_r[i-1];
      assign num1_in  = num1_r[i-1];
      assign num2_in  = num2_r[i-1];
      assign q1_in    = q1_r[i-1];
      assign q2_in    = q2_r[i-1];
      assign sat1_in  = sat1_r[i-1];
      assign sat2_in  = sat2_r[i-1];
    end

    assign sa  = DEN_W'(ctx_in.a) << K;
    assign ge1 = (DEN_W'(num1_in) >= sa);
    assign ge2 = (DEN_W'(num2_in) >= sa);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      ctx_r[i]   <= ctx_in;
      count_r[i] <= count_in;
      sat1_r[i]  <= sat1_in;
      sat2_r[i]  <= sat2_in;
      num1_r[i]  <= ge1 ? num1_in - sa[NUM_W-1:0] : num1_in;
      num2_r[i]  <= ge2 ? num2_in - sa[NUM_W-1:0] : num2_in;
      q1_r[i]    <= ge1 ? (q1_in | (QUO_BITS'(1) << K)) : q1_in;
      q2_r[i]    <= ge2 ? (q2_in | (QUO_BITS'(1) << K)) : q2_in;
    end
  end

  assign out_valid = v_r[QUO_BITS-1];
  assign out_ctx   = ctx_r[QUO_BITS-1];
  assign out_count = count_r[QUO_BITS-1];
  assign out_dist1 = sat1_r[QUO_BITS-1] ? DIST_MAX : {1'b0, q1_r[QUO_BITS-1]};
  assign out_dist2 = sat2_r[QUO_BITS-1] ? DIST_MAX : {1'b0, q2_r[QUO_BITS-1]};

endmodule

// File: design/rci_hit.sv
// hit points from the distances and the output register
module rci_hit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rci_pkg::ctx_t     in_ctx,
  input  logic [1:0]        in_count,
  input  logic [31:0]       in_dist1,
  input  logic [31:0]       in_dist2,
  output logic              out_valid,
  output rci_pkg::ray_out_t out_data
);
  import rci_pkg::*;

  logic               va_r;
  logic signed [31:0] ox_r, oz_r;
  logic               inside_r;
  logic [1:0]         count_r;
  logic [31:0]        d1_r, d2_r;
  logic signed [63:0] px1_r, pz1_r, px2_r, pz2_r;
  logic               out_valid_r;
  ray_out_t           out_r, out_nxt;

  // o + floor(p / 2^16), clamped to 32 bits
  function automatic logic signed [31:0] sat_coord(input logic signed [31:0] o,
                                                   input logic signed [63:0] p);
    logic signed [48:0] s;
    s = 49'($signed(p[63:16])) + 49'(o);
    if (s[48:31] == '0 || s[48:31] == '1) begin
      return s[31:0];
    end else if (s[48]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      va_r        <= in_valid;
      out_valid_r <= va_r;
    end
  end

  always_comb begin
    out_nxt            = '0;
    out_nxt.inside_res = inside_r;
    out_nxt.hit_count  = count_r;
    if (count_r != 2'd0) begin
      out_nxt.first_distance = $signed(d1_r);
      out_nxt.first_normal_x = sat_coord(ox_r, px1_r);
      out_nxt.first_normal_z = sat_coord(oz_r, pz1_r);
    end
    if (count_r == 2'd2) begin
      out_nxt.second_distance = $signed(d2_r);
      out_nxt.second_normal_x = sat_coord(ox_r, px2_r);
      out_nxt.second_normal_z = sat_coord(oz_r, pz2_r);
    end
  end

  always_ff @(posedge clk) begin
    ox_r     <= in_ctx.ox;
    oz_r     <= in_ctx.oz;
    inside_r <= in_ctx.in_cyl;
    count_r  <= in_count;
    d1_r     <= in_dist1;
    d2_r     <= in_dist2;
    px1_r    <= smul(in_ctx.dx, $signed(in_dist1));
    pz1_r    <= smul(in_ctx.dz, $signed(in_dist1));
    px2_r    <= smul(in_ctx.dx, $signed(in_dist2));
    pz2_r    <= smul(in_ctx.dz, $signed(in_dist2));
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: design/ray_cylinder_intersection.sv
// ray against the infinite unit cylinder about y, fully pipelined
// pipeline: 89 register stages: 6 coefficient, 48 root, 33 divider and 2 output stages
// throughput: one ray per clock, busy stays low
// reset: synchronous active-low rst_n clears only the pipeline valid bits
module ray_cylinder_intersection (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rci_pkg::ray_in_t  in_data,
  output logic              out_valid,
  output rci_pkg::ray_out_t out_data
);
  import rci_pkg::*;

  logic                 accept;
  logic                 coef_valid, sqrt_valid, div_valid;
  ctx_t                 coef_ctx, sqrt_ctx, div_ctx;
  logic [DISC_W-1:0]    coef_disc;
  logic [SQRT_BITS-1:0] sqrt_root;
  logic [1:0]           div_count;
  logic [31:0]          div_dist1, div_dist2;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rci_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_ray    (in_data),
    .out_valid (coef_valid),
    .out_ctx   (coef_ctx),
    .out_disc  (coef_disc)
  );

  rci_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (coef_valid),
    .in_ctx    (coef_ctx),
    .in_disc   (coef_disc),
    .out_valid (sqrt_valid),
    .out_ctx   (sqrt_ctx),
    .out_root  (sqrt_root)
  );

  rci_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sqrt_valid),
    .in_ctx    (sqrt_ctx),
    .in_root   (sqrt_root),
    .out_valid (div_valid),
    .out_ctx   (div_ctx),
    .out_count (div_count),
    .out_dist1 (div_dist1),
    .out_dist2 (div_dist2)
  );

  rci_hit u_hit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ctx    (div_ctx),
    .in_count  (div_count),
    .in_dist1  (div_dist1),
    .in_dist2  (div_dist2),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: design/rci_checker.sv
// port-level checks for the ray cylinder intersection, bound to the top level
`include "ray_cylinder_intersection_macros.svh"

module rci_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input rci_pkg::ray_out_t out_data
);

  `RCI_ASSERT(a_never_busy, clk, rst_n, !busy, "busy raised on a fully pipelined block")
  `RCI_ASSERT_IMP(a_count_range, clk, rst_n, out_valid, out_data.hit_count != 2'd3, "hit count out of range")
  `RCI_ASSERT_IMP(a_second_clear, clk, rst_n, out_valid && (out_data.hit_count != 2'd2), (out_data.second_distance == 0) && (out_data.second_normal_x == 0) && (out_data.second_normal_z == 0), "unused second hit not zero")
  `RCI_ASSERT_IMP(a_hit_order, clk, rst_n, out_valid && (out_data.hit_count == 2'd2), out_data.first_distance <= out_data.second_distance, "hits out of order")

endmodule

bind ray_cylinder_intersection rci_checker u_rci_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// File: tb/ray_cylinder_intersection_tb.sv
// testbench for the ray against infinite unit cylinder pipeline
`timescale 1ns / 1ps

module ray_cylinder_intersection_tb;
  import rci_pkg::*;

  localparam int LATENCY   = 89;
  localparam int MAX_CYCLES = 600000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  ray_in_t  in_data;
  logic     out_valid;
  ray_out_t out_data;

  ray_out_t hit_queue[$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       idle_pct;

  ray_cylinder_intersection DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // floor(n * 2^16 / a), saturated
  function automatic logic [31:0] ray_distance(logic [127:0] n, logic [127:0] a);
    logic [127:0] q;
    q = (n << 16) / a;
    if (q > 128'h7fff_ffff) return 32'h7fff_ffff;
    return q[31:0];
  endfunction

  // origin + floor(dir * t / 2^16), saturated to 32 bits
  function automatic logic signed [31:0] hit_point(logic signed [31:0] o,
                                                   logic signed [31:0] d,
                                                   logic [31:0] t);
    logic signed [127:0] p;
    p = (128'(d) * $signed({96'd0, t})) >>> 16;
    p = p + 128'(o);
    if (p > 128'sh7fff_ffff) return 32'h7fff_ffff;
    if (p < -128'sh8000_0000) return 32'h8000_0000;
    return p[31:0];
  endfunction

  function automatic ray_out_t predict_hits(ray_in_t r);
    ray_out_t res;
    logic signed [127:0] ox, oz, dx, dz, a, b, cr, disc, s, root[2];
    logic [127:0] lo, hi, mid;
    int nroots, cnt;
    logic [31:0] t;
    ox = 128'(r.origin_x); oz = 128'(r.origin_z);
    dx = 128'(r.dir_x);    dz = 128'(r.dir_z);
    res = '0;
    res.inside_res = (ox * ox + oz * oz) <= 128'sh1_0000_0000;
    a = dx * dx + dz * dz;
    nroots = 0;
    if (a != 0) begin
      b = ox * dx + oz * dz;
      cr = ox * dz - oz * dx;
      disc = (a <<< 32) - cr * cr;
      if (disc == 0) begin
        root[0] = -b;
        nroots = 1;
      end else if (disc > 0) begin
        lo = 0; hi = 128'h1_0000_0000_0000;
        while (hi - lo > 1) begin
          mid = (lo + hi) >> 1;
          if (mid * mid <= disc) lo = mid; else hi = mid;
        end
        s = lo;
        root[0] = -b - s;
        root[1] = -b + s;
        nroots = 2;
      end
    end
    cnt = 0;
    for (int i = 0; i < nroots; i++) begin
      if (root[i] >= 0) begin
        t = ray_distance(root[i], a);
        if (cnt == 0) begin
          res.first_distance = t;
          res.first_normal_x = hit_point(r.origin_x, r.dir_x, t);
          res.first_normal_z = hit_point(r.origin_z, r.dir_z, t);
        end else begin
          res.second_distance = t;
          res.second_normal_x = hit_point(r.origin_x, r.dir_x, t);
          res.second_normal_z = hit_point(r.origin_z, r.dir_z, t);
        end
        cnt++;
      end
    end
    res.hit_count = cnt[1:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      ray_out_t e;
      if (hit_queue.size() == 0) begin
        $display("unexpected result beat");
        error_count++;
      end else begin
        e = hit_queue.pop_front();
        if (out_data.inside_res != e.inside_res)
          report_mismatch("inside_res", 32'(out_data.inside_res), 32'(e.inside_res));
        if (out_data.hit_count != e.hit_count)
          report_mismatch("hit_count", 32'(out_data.hit_count), 32'(e.hit_count));
        if (out_data.first_distance != e.first_distance)
          report_mismatch("first_distance", out_data.first_distance, e.first_distance);
        if (out_data.first_normal_x != e.first_normal_x)
          report_mismatch("first_normal_x", out_data.first_normal_x, e.first_normal_x);
        if (out_data.first_normal_z != e.first_normal_z)
          report_mismatch("first_normal_z", out_data.first_normal_z, e.first_normal_z);
        if (out_data.second_distance != e.second_distance)
          report_mismatch("second_distance", out_data.second_distance, e.second_distance);
        if (out_data.second_normal_x != e.second_normal_x)
          report_mismatch("second_normal_x", out_data.second_normal_x, e.second_normal_x);
        if (out_data.second_normal_z != e.second_normal_z)
          report_mismatch("second_normal_z", out_data.second_normal_z, e.second_normal_z);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout");
      $display("TEST FAILED");
      $finish;
    end
  end

  // send one ray; start stays high across back-to-back beats
  task automatic send_ray(ray_in_t r);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    hit_queue.push_back(predict_hits(r));
  endtask

  task automatic send_rays(logic signed [31:0] ox, logic signed [31:0] oz,
                           logic signed [31:0] dx, logic signed [31:0] dz);
    ray_in_t r;
    r.origin_x = ox; r.origin_z = oz; r.dir_x = dx; r.dir_z = dz;
    send_ray(r);
  endtask

  task automatic test_directed();
    send_rays(32'sh0, 32'sh0, 32'sh1_0000, 32'sh0);          // from center
    send_rays(-32'sh3_0000, 32'sh0, 32'sh1_0000, 32'sh0);    // two hits ahead
    send_rays(32'sh3_0000, 32'sh0, 32'sh1_0000, 32'sh0);     // both behind
    send_rays(-32'sh3_0000, 32'sh1_0000, 32'sh1_0000, 32'sh0); // tangent
    send_rays(-32'sh3_0000, 32'sh2_0000, 32'sh1_0000, 32'sh0); // miss
    send_rays(32'sh5000, 32'sh7000, 32'sh0, 32'sh0);         // parallel to axis
    send_rays(32'sh1_0000, 32'sh0, 32'sh0, 32'sh1_0000);     // on the surface
    send_rays(-32'sh3_0000, 32'shffff, 32'sh1_0000, 32'sh0); // near tangent
    send_rays(-32'sh7fff_ffff - 1, 32'sh0, 32'sh1, 32'sh0);  // distance overflow
    send_rays(-32'sh7fff_ffff - 1, -32'sh7fff_ffff - 1,
              32'sh7fff_ffff, 32'sh7fff_ffff);
    send_rays(32'sh7fff_ffff, 32'sh7fff_ffff,
              -32'sh7fff_ffff - 1, -32'sh7fff_ffff - 1);
    send_rays(32'sh0, 32'sh0, 32'sh1, 32'sh1);               // tiny direction
    send_rays(32'sh0, 32'sh0, -32'sh7fff_ffff - 1, 32'sh0);  // huge direction
    send_rays(-32'sh2_0000, -32'sh2_0000, 32'sh1_0000, 32'sh1_0000);
    send_rays(32'shb505, 32'shb505, 32'sh0, -32'sh1_0000);
    send_rays(32'sh7fff_ffff, -32'sh7fff_ffff - 1, 32'sh1, -32'sh1);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3, 0))
      0: return $urandom;
      1: return $signed($urandom_range(32'h6_0000, 0)) - 32'sh3_0000;
      2: return $signed($urandom_range(32'h2_2000, 0)) - 32'sh1_1000;
      default: return $signed($urandom_range(64, 0)) - 32'sd32;
    endcase
  endfunction

  task automatic test_random(int n, int pct);
    ray_in_t r;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      r.origin_x = rand_coord(); r.origin_z = rand_coord();
      r.dir_x = rand_coord();    r.dir_z = rand_coord();
      // mostly aim the ray back toward the axis so hits are common
      if ($urandom_range(2, 0) != 0) begin
        r.dir_x = -(r.origin_x >>> $urandom_range(4, 0)) + ($urandom_range(255, 0) - 128);
        r.dir_z = -(r.origin_z >>> $urandom_range(4, 0)) + ($urandom_range(255, 0) - 128);
      end
      send_ray(r);
    end
    start <= 1'b0;
    idle_pct = 0;
  endtask

  initial begin
    int waited;
    rst_n = 1'b0; start = 1'b0; in_data = '0;
    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500, 0);
    test_random(300, 84);
    test_random(530, 11);
    start <= 1'b0;
    waited = 0;
    while (hit_queue.size() != 0 && waited < 10 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY) @(posedge clk);
    if (error_count == 0 && hit_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: ray_cylinder_intersection.f
+incdir+design
design/rci_pkg.sv
design/rci_coef.sv
design/rci_sqrt.sv
design/rci_div.sv
design/rci_hit.sv
design/ray_cylinder_intersection.sv
design/rci_checker.sv
tb/ray_cylinder_intersection_tb.sv
